[src/bounded_priority_queue_with_deferral_defines.svh]
// assertion macros for the bounded priority queue
// no dependencies
`ifndef BOUNDED_PRIORITY_QUEUE_WITH_DEFERRAL_DEFINES_SVH
`define BOUNDED_PRIORITY_QUEUE_WITH_DEFERRAL_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define BPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

[src/bpq_pkg.sv]
// package for the bounded priority queue: types, codes and constants
// no dependencies
`timescale 1ns / 1ps

package bpq_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam logic [7:0] DAY_LIMIT_RESET = 8'd3;

    // operation codes
    localparam logic [2:0] OP_ADMIT  = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_SERVE  = 3'd2;
    localparam logic [2:0] OP_SERVEK = 3'd3;
    localparam logic [2:0] OP_CANCEL = 3'd4;
    localparam logic [2:0] OP_DEFER  = 3'd5;

    // status codes
    localparam logic [3:0] ST_QUEUED    = 4'd0;
    localparam logic [3:0] ST_TAIL_DEF  = 4'd1;
    localparam logic [3:0] ST_NEW_DEF   = 4'd2;
    localparam logic [3:0] ST_SERVED    = 4'd3;
    localparam logic [3:0] ST_CANCELLED = 4'd4;
    localparam logic [3:0] ST_MOVED     = 4'd5;
    localparam logic [3:0] ST_NOT_FOUND = 4'd6;
    localparam logic [3:0] ST_EMPTY     = 4'd7;
    localparam logic [3:0] ST_FULL      = 4'd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_REPLY
    } state_t;

    // one stored entry
    typedef struct packed {
        logic [63:0] key;
        logic [11:0] tim;
        logic [2:0]  pri;
    } entry_t;

endpackage

[src/bounded_priority_queue_with_deferral.sv]
// top level of the bounded priority queue with deferral
// depends on bpq_pkg, bpq_ctrl and the assertion macro header
//
// Usage: an input item (op, entry_key, entry_time, entry_priority) is taken
// on in_valid and in_ready; exactly one result item (status, out_key,
// out_time, out_priority, queue_count, served_tally) follows on out_valid.
// day_limit is written on cfg_valid and cfg_ready; the user writes it only
// while the block is idle, which the block itself does not enforce.
// Entries live in a single-port-write memory walked by one compare unit:
// codes decided at once go straight to the reply; other items scan and
// shift the sorted store, each entry visited taking a read and then a
// compare or a write once the registered read is back. One item is in
// work at a time; in_ready is low until its result has been taken. A
// stalled receiver holds the result and the block.
// Reset clears the held count and served tally and sets day_limit to 3;
// the entry memory is not cleared, since only held entries are read.
`timescale 1ns / 1ps

`include "bounded_priority_queue_with_deferral_defines.svh"

module bounded_priority_queue_with_deferral #(
    parameter int CAPACITY = bpq_pkg::DEF_CAPACITY,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  day_limit,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [63:0] entry_key,
    input  logic [11:0] entry_time,
    input  logic [2:0]  entry_priority,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [63:0] out_key,
    output logic [11:0] out_time,
    output logic [2:0]  out_priority,
    output logic [CW-1:0] queue_count,
    output logic [7:0]  served_tally
);
    import bpq_pkg::*;

    logic [7:0] limit_reg;
    entry_t     res_entry;
    logic       busy;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= DAY_LIMIT_RESET;
        else if (cfg_valid && cfg_ready)
            limit_reg <= day_limit;
    end

    bpq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .entry_key(entry_key), .entry_time(entry_time),
        .entry_priority(entry_priority), .day_limit(limit_reg),
        .res_valid(out_valid), .res_ready(out_ready),
        .res_status(status), .res_entry(res_entry),
        .res_count(queue_count), .res_tally(served_tally), .busy(busy)
    );

    assign out_key = res_entry.key;
    assign out_time = res_entry.tim;
    assign out_priority = res_entry.pri;

    // checks
    `BPQ_ASSERT(a_count_bound, queue_count <= CW'(CAPACITY), "queue count beyond capacity")
    `BPQ_ASSERT(a_no_accept_busy, busy |-> !in_ready, "item accepted while busy")
    `BPQ_ASSERT(a_tally_mono, served_tally >= $past(served_tally), "served tally went down")

endmodule

[src/bpq_store.sv]
// entry memory: one write port, one registered read port
// depends on bpq_pkg
`timescale 1ns / 1ps

module bpq_store #(
    parameter int CAPACITY = bpq_pkg::DEF_CAPACITY,
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  bpq_pkg::entry_t wr_data,
    input  logic [AW-1:0]   rd_addr,
    output bpq_pkg::entry_t rd_data
);
    import bpq_pkg::*;

    entry_t mem [CAPACITY];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[src/bpq_ctrl.sv]
// sequencer: scans and shifts the entry memory one entry per step
// depends on bpq_pkg and bpq_store
`timescale 1ns / 1ps

module bpq_ctrl #(
    parameter int CAPACITY = bpq_pkg::DEF_CAPACITY,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [63:0] entry_key,
    input  logic [11:0] entry_time,
    input  logic [2:0]  entry_priority,
    input  logic [7:0]  day_limit,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [3:0]  res_status,
    output bpq_pkg::entry_t res_entry,
    output logic [CW-1:0] res_count,
    output logic [7:0]  res_tally,
    output logic        busy
);
    import bpq_pkg::*;

    state_t state_reg, state_next;
    logic [2:0]  op_reg;
    entry_t      new_reg, out_reg, out_next;
    logic [CW-1:0] held_reg, held_next;
    logic [7:0]  tally_reg, tally_next;
    logic [3:0]  status_reg, status_next;
    // idx_reg walks the memory; pos_reg is the target position
    logic [CW-1:0] idx_reg, idx_next, pos_reg, pos_next;
    logic        rd_pend_reg, rd_pend_next;
    // after removal, an insert may follow (tail eviction)
    logic        ins_after_reg, ins_after_next;
    logic        op_reg_en;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    entry_t        wr_data, rd_data;

    bpq_store #(.CAPACITY(CAPACITY)) u_store (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    logic [8:0] day_used;
    assign day_used = 9'(held_reg) + 9'(tally_reg);
    assign in_ready = (state_reg == S_IDLE);
    assign busy = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_REPLY);
    assign res_status = status_reg;
    assign res_entry = out_reg;
    assign res_count = held_reg;
    assign res_tally = tally_reg;
    assign op_reg_en = in_valid && in_ready;

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg <= '0;
            tally_reg <= '0;
            rd_pend_reg <= 1'b0;
            ins_after_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg <= held_next;
            tally_reg <= tally_next;
            rd_pend_reg <= rd_pend_next;
            ins_after_reg <= ins_after_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (op_reg_en)
        begin
            op_reg <= op;
            new_reg <= '{key: entry_key, tim: entry_time, pri: entry_priority};
        end
        out_reg <= out_next;
        status_reg <= status_next;
        idx_reg <= idx_next;
        pos_reg <= pos_next;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        held_next = held_reg;
        tally_next = tally_reg;
        out_next = out_reg;
        status_next = status_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        rd_pend_next = 1'b0;
        ins_after_next = ins_after_reg;
        wr_en = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = rd_data;
        rd_addr = idx_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (op_reg_en)
                begin
                    out_next = '0;
                    status_next = ST_NOT_FOUND;
                    ins_after_next = 1'b0;
                    idx_next = '0;
                    state_next = S_SCAN;
                    rd_pend_next = 1'b1;
                    priority if (op > OP_DEFER)
                        state_next = S_REPLY;
                    else if (op == OP_ADMIT)
                    begin
                        if (day_used >= 9'(day_limit))
                        begin
                            if (held_reg == '0)
                            begin
                                out_next = '{key: entry_key, tim: entry_time,
                                             pri: entry_priority};
                                status_next = ST_NEW_DEF;
                                state_next = S_REPLY;
                            end
                            else
                            begin
                                // look at the tail first
                                idx_next = held_reg - 1'b1;
                                ins_after_next = 1'b1;
                            end
                        end
                        else if (held_reg == CW'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            state_next = S_REPLY;
                        end
                    end
                    else if (op == OP_LOAD && held_reg == CW'(CAPACITY))
                    begin
                        status_next = ST_FULL;
                        state_next = S_REPLY;
                    end
                    else if ((op == OP_SERVE || op == OP_DEFER) && held_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        state_next = S_REPLY;
                    end
                    rd_addr = idx_next[AW-1:0];
                end
            end
            S_SCAN:
            begin
                // compare against the entry at idx_reg once its registered read is back
                if (rd_pend_reg)
                begin
                    rd_addr = idx_reg[AW-1:0];
                end
                else if (ins_after_reg)
                begin
                    if (new_reg.pri > rd_data.pri)
                    begin
                        out_next = rd_data;
                        status_next = ST_TAIL_DEF;
                        held_next = held_reg - 1'b1;
                        idx_next = '0;
                        ins_after_next = 1'b0;
                        rd_pend_next = 1'b1;
                        rd_addr = '0;
                    end
                    else
                    begin
                        out_next = new_reg;
                        status_next = ST_NEW_DEF;
                        state_next = S_REPLY;
                    end
                end
                else if (op_reg == OP_ADMIT || op_reg == OP_LOAD)
                begin
                    if (idx_reg == held_reg || rd_data.pri < new_reg.pri)
                    begin
                        // insert here: move the tail up first
                        pos_next = idx_reg;
                        idx_next = held_reg;
                        if (status_next != ST_TAIL_DEF)
                            status_next = ST_QUEUED;
                        rd_pend_next = 1'b1;
                        rd_addr = AW'(held_reg - 1'b1);
                        state_next = S_SHIFT_UP;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_pend_next = 1'b1;
                        rd_addr = idx_next[AW-1:0];
                    end
                end
                else
                begin
                    if (idx_reg == held_reg)
                        state_next = S_REPLY;
                    else if (op_reg == OP_SERVE || rd_data.key == new_reg.key)
                    begin
                        out_next = rd_data;
                        if (op_reg == OP_CANCEL)
                            status_next = ST_CANCELLED;
                        else if (op_reg == OP_DEFER)
                            status_next = ST_MOVED;
                        else
                        begin
                            status_next = ST_SERVED;
                            if (tally_reg != 8'hFF)
                                tally_next = tally_reg + 8'd1;
                        end
                        rd_pend_next = 1'b1;
                        rd_addr = AW'(idx_reg + 1'b1);
                        state_next = S_SHIFT_DOWN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_pend_next = 1'b1;
                        rd_addr = idx_next[AW-1:0];
                    end
                end
            end
            S_SHIFT_UP:
            begin
                // entry idx-1 moves to idx, until pos is reached
                rd_addr = AW'(idx_reg - 1'b1);
                if (idx_reg == pos_reg)
                begin
                    wr_en = 1'b1;
                    wr_addr = pos_reg[AW-1:0];
                    wr_data = new_reg;
                    held_next = held_reg + 1'b1;
                    state_next = S_REPLY;
                end
                else if (rd_pend_reg)
                begin
                    rd_pend_next = 1'b0;
                end
                else
                begin
                    wr_en = 1'b1;
                    idx_next = idx_reg - 1'b1;
                    rd_pend_next = 1'b1;
                    rd_addr = AW'(idx_next - 1'b1);
                end
            end
            S_SHIFT_DOWN:
            begin
                // entry idx+1 moves to idx, until the end
                rd_addr = AW'(idx_reg + 1'b1);
                if (idx_reg + 1'b1 >= held_reg)
                begin
                    held_next = held_reg - 1'b1;
                    state_next = S_REPLY;
                end
                else if (!rd_pend_reg)
                begin
                    wr_en = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    rd_pend_next = 1'b1;
                    rd_addr = AW'(idx_next + 1'b1);
                end
            end
            S_REPLY:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[tb/tb_top.sv]
// testbench for the bounded priority queue with deferral: stimulus, queue predictor, checks
// depends on bpq_pkg and the bounded_priority_queue_with_deferral top level
`timescale 1ns / 1ps

// predicted queue contents and the results still to come
class queue_scoreboard;
    bit [63:0] keys[$];
    bit [11:0] times[$];
    bit [2:0]  pris[$];
    int unsigned served;
    int unsigned limit;
    bit [3:0]  exp_status[$];
    bit [63:0] exp_key[$];
    bit [11:0] exp_time[$];
    bit [2:0]  exp_pri[$];
    bit [4:0]  exp_count[$];
    bit [7:0]  exp_tally[$];
    int errors;

    function new();
        served = 0;
        limit = 3;
        errors = 0;
    endfunction

    function int pending();
        return exp_status.size();
    endfunction

    // insert behind every entry of the same or higher priority
    function void insert_entry(bit [63:0] k, bit [11:0] t, bit [2:0] p);
        int pos;
        pos = 0;
        while (pos < pris.size() && pris[pos] >= p)
            pos++;
        keys.insert(pos, k);
        times.insert(pos, t);
        pris.insert(pos, p);
    endfunction

    function int find_key(bit [63:0] k);
        foreach (keys[i])
            if (keys[i] == k)
                return i;
        return -1;
    endfunction

    // work out the result of one accepted input item
    function void note_input(bit [2:0] op, bit [63:0] k, bit [11:0] t, bit [2:0] p);
        bit [3:0]  st;
        bit [63:0] rk;
        bit [11:0] rt;
        bit [2:0]  rp;
        int idx;
        st = bpq_pkg::ST_NOT_FOUND;
        rk = 0;
        rt = 0;
        rp = 0;
        idx = -1;
        case (op)
            bpq_pkg::OP_ADMIT:
            begin
                if (keys.size() + served >= limit) begin
                    if (keys.size() > 0 && p > pris[keys.size() - 1]) begin
                        rk = keys.pop_back();
                        rt = times.pop_back();
                        rp = pris.pop_back();
                        insert_entry(k, t, p);
                        st = bpq_pkg::ST_TAIL_DEF;
                    end
                    else begin
                        rk = k;
                        rt = t;
                        rp = p;
                        st = bpq_pkg::ST_NEW_DEF;
                    end
                end
                else if (keys.size() >= 16)
                    st = bpq_pkg::ST_FULL;
                else begin
                    insert_entry(k, t, p);
                    st = bpq_pkg::ST_QUEUED;
                end
            end
            bpq_pkg::OP_LOAD:
            begin
                if (keys.size() >= 16)
                    st = bpq_pkg::ST_FULL;
                else begin
                    insert_entry(k, t, p);
                    st = bpq_pkg::ST_QUEUED;
                end
            end
            bpq_pkg::OP_SERVE:
            begin
                if (keys.size() == 0)
                    st = bpq_pkg::ST_EMPTY;
                else begin
                    idx = 0;
                    st = bpq_pkg::ST_SERVED;
                end
            end
            bpq_pkg::OP_SERVEK:
            begin
                idx = find_key(k);
                if (idx >= 0)
                    st = bpq_pkg::ST_SERVED;
            end
            bpq_pkg::OP_CANCEL:
            begin
                idx = find_key(k);
                if (idx >= 0)
                    st = bpq_pkg::ST_CANCELLED;
            end
            bpq_pkg::OP_DEFER:
            begin
                if (keys.size() == 0)
                    st = bpq_pkg::ST_EMPTY;
                else begin
                    idx = find_key(k);
                    if (idx >= 0)
                        st = bpq_pkg::ST_MOVED;
                end
            end
            default:
                st = bpq_pkg::ST_NOT_FOUND;
        endcase
        // remove a found entry
        if (idx >= 0) begin
            rk = keys[idx];
            rt = times[idx];
            rp = pris[idx];
            keys.delete(idx);
            times.delete(idx);
            pris.delete(idx);
            if (st == bpq_pkg::ST_SERVED && served < 255)
                served++;
        end
        exp_status.push_back(st);
        exp_key.push_back(rk);
        exp_time.push_back(rt);
        exp_pri.push_back(rp);
        exp_count.push_back(5'(keys.size()));
        exp_tally.push_back(8'(served));
    endfunction

    // compare one result item with the oldest expectation
    function void check_result(bit [3:0] st, bit [63:0] k, bit [11:0] t, bit [2:0] p,
                               bit [4:0] cnt, bit [7:0] tally);
        bit [3:0]  es;
        bit [63:0] ek;
        bit [11:0] et;
        bit [2:0]  ep;
        bit [4:0]  ec;
        bit [7:0]  etl;
        if (exp_status.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: status %0d key %h", st, k);
            return;
        end
        es = exp_status.pop_front();
        ek = exp_key.pop_front();
        et = exp_time.pop_front();
        ep = exp_pri.pop_front();
        ec = exp_count.pop_front();
        etl = exp_tally.pop_front();
        if (st !== es || k !== ek || t !== et || p !== ep || cnt !== ec || tally !== etl) begin
            errors++;
            if (errors <= 10)
            begin
                $display("mismatch: exp st %0d key %h t %0d p %0d cnt %0d tally %0d",
                         es, ek, et, ep, ec, etl);
                $display("          got st %0d key %h t %0d p %0d cnt %0d tally %0d",
                         st, k, t, p, cnt, tally);
            end
        end
    endfunction
endclass

module tb_top;
    import bpq_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  day_limit;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  op;
    logic [63:0] entry_key;
    logic [11:0] entry_time;
    logic [2:0]  entry_priority;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  status;
    logic [63:0] out_key;
    logic [11:0] out_time;
    logic [2:0]  out_priority;
    logic [4:0]  queue_count;
    logic [7:0]  served_tally;

    queue_scoreboard sb;
    int send_idle;
    int recv_idle;
    int hold_cycles;
    int stall_count;
    bit done;
    bit [63:0] key_pool[8];

    bounded_priority_queue_with_deferral i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .day_limit(day_limit),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .entry_key(entry_key),
        .entry_time(entry_time),
        .entry_priority(entry_priority),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .out_key(out_key),
        .out_time(out_time),
        .out_priority(out_priority),
        .queue_count(queue_count),
        .served_tally(served_tally)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // accepted items feed the predictor and the checker
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_input(op, entry_key, entry_time, entry_priority);
        if (rst_n && out_valid && out_ready)
            sb.check_result(status, out_key, out_time, out_priority, queue_count,
                            served_tally);
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !rst_n || hold_cycles > 0)
            stall_count <= 0;
        else begin
            stall_count <= stall_count + 1;
            if (stall_count > 20000 && !done) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // offer one item and wait for acceptance; valid drops only while idling
    task automatic send_item(bit [2:0] o, bit [63:0] k, bit [11:0] t, bit [2:0] p);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        entry_key <= k;
        entry_time <= t;
        entry_priority <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // wait for every expected result, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() > 0 || hold_cycles > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_limit(bit [7:0] v);
        drain();
        cfg_valid <= 1'b1;
        day_limit <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.limit = v;
    endtask

    // random item, mostly keys from a small pool so searches hit
    task automatic send_random();
        bit [2:0]  o;
        bit [63:0] k;
        bit [2:0]  p;
        int r;
        r = $urandom_range(99);
        if (r < 30) o = OP_ADMIT;
        else if (r < 45) o = OP_LOAD;
        else if (r < 60) o = OP_SERVE;
        else if (r < 72) o = OP_SERVEK;
        else if (r < 84) o = OP_CANCEL;
        else if (r < 96) o = OP_DEFER;
        else o = 3'($urandom_range(7, 6));
        if ($urandom_range(9) < 8)
            k = key_pool[$urandom_range(7)];
        else
            k = {$urandom, $urandom};
        p = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        send_item(o, k, ($urandom_range(9) == 0) ? 12'($urandom_range(4095)) :
                  12'($urandom_range(2359)), p);
    endtask

    initial
    begin
        int n;
        sb = new();
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        day_limit = 8'd0;
        in_valid = 1'b0;
        op = OP_ADMIT;
        entry_key = 64'd0;
        entry_time = 12'd0;
        entry_priority = 3'd0;
        send_idle = 0;
        recv_idle = 0;
        hold_cycles = 0;
        stall_count = 0;
        done = 1'b0;
        foreach (key_pool[i])
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = 64'h0;
        key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-queue cases, day full on reset limit, eviction
        send_item(OP_SERVE, 64'd0, 12'd0, 3'd0);
        send_item(OP_DEFER, 64'd1, 12'd0, 3'd0);
        send_item(OP_SERVEK, 64'd1, 12'd0, 3'd0);
        send_item(OP_CANCEL, 64'd1, 12'd0, 3'd0);
        send_item(3'd6, 64'd0, 12'd0, 3'd0);
        send_item(3'd7, 64'd0, 12'd0, 3'd0);
        send_item(OP_ADMIT, key_pool[1], 12'd2359, 3'd2);
        send_item(OP_ADMIT, key_pool[0], 12'd0, 3'd2);
        send_item(OP_ADMIT, key_pool[2], 12'd4095, 3'd1);
        send_item(OP_ADMIT, key_pool[3], 12'd800, 3'd1);
        send_item(OP_ADMIT, key_pool[4], 12'd900, 3'd4);
        send_item(OP_ADMIT, key_pool[5], 12'd900, 3'd7);
        send_item(OP_DEFER, key_pool[6], 12'd0, 3'd0);
        send_item(OP_DEFER, key_pool[5], 12'd0, 3'd0);
        send_item(OP_SERVEK, key_pool[4], 12'd0, 3'd0);
        send_item(OP_CANCEL, key_pool[1], 12'd0, 3'd0);
        send_item(OP_SERVE, 64'd0, 12'd0, 3'd0);

        // day limit zero: admits deferred unless they outrank the tail, loads fill to full
        write_limit(8'd0);
        send_item(OP_ADMIT, key_pool[6], 12'd100, 3'd3);
        for (n = 0; n < 18; n++)
            send_item(OP_LOAD, key_pool[n % 8], 12'(n), 3'(n % 8));
        send_item(OP_ADMIT, key_pool[7], 12'd5, 3'd7);

        // receiver holds off while the sender keeps offering
        hold_cycles = 300;
        for (n = 0; n < 6; n++)
            send_item(OP_SERVE, 64'd0, 12'd0, 3'd0);
        drain();

        // phases: limit settings and idling patterns
        for (n = 0; n < 1930; n++) begin
            if (n == 0) write_limit(8'd255);
            else if (n == 500) write_limit(8'd10);
            else if (n == 900) write_limit(8'd3);
            else if (n == 1300) write_limit(8'd20);
            if (n < 650) begin
                send_idle = 29;
                recv_idle = 54;
            end
            else if (n < 1300) begin
                send_idle = 54;
                recv_idle = 29;
            end
            else begin
                send_idle = 0;
                recv_idle = 0;
            end
            // sender pause until everything has come back
            if (n == 1000)
                drain();
            send_random();
        end

        drain();
        done = 1'b1;
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
